@@ design/brr_pkg.sv @@
// ----------------------------------------------------------------------------
// brr_pkg : shared types, constants and helpers
// Register map codes, queue entry and derived range settings used by the
// front end, the queue, the threshold divider and the back end.
// ----------------------------------------------------------------------------
package brr_pkg;

    localparam int WORD_W      = 64;
    localparam int HALF_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS   = 32;
    localparam int ADDR_W      = 5;
    localparam int IDX_W       = 2;

    localparam logic [IDX_W-1:0] REG_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] REG_MODE = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              is64;
        logic              full;
    } brr_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] lo;
        logic [HALF_W-1:0] w32;
        logic              full32;
        logic [WORD_W-1:0] w64;
        logic [WORD_W-1:0] mask64;
        logic              full64;
        logic              is64;
    } brr_cfg_t;

    function automatic logic [WORD_W-1:0] smear64(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] m;
        m = v;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        m = m | (m >> 32);
        return m;
    endfunction

    // Sign bias cancels in both the width and the result, so the signed
    // modes reduce exactly like the unsigned ones of the same width.
    function automatic brr_cfg_t derive_cfg(input logic [WORD_W-1:0] lo,
                                            input logic [WORD_W-1:0] hi,
                                            input logic [1:0]        mode);
        brr_cfg_t          c;
        logic [HALF_W-1:0] span32;
        logic [WORD_W-1:0] span64;
        span32   = hi[HALF_W-1:0] - lo[HALF_W-1:0];
        span64   = hi - lo;
        c.lo     = lo;
        c.w32    = span32 + 32'd1;
        c.full32 = &span32;
        c.w64    = span64 + 64'd1;
        c.mask64 = smear64(span64);
        c.full64 = &span64;
        c.is64   = mode[0];
        return c;
    endfunction

endpackage

@@ design/brr_front.sv @@
// ----------------------------------------------------------------------------
// brr_front : request intake and classification
// Registers each random word with its width class and full-range flag and
// hands it to the queue; stalls during a threshold rebuild and on queue back-pressure.
// ----------------------------------------------------------------------------
module brr_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [63:0]               random_word,
    input  brr_pkg::brr_cfg_t         cfg,
    input  logic                      thr_ready,
    input  logic                      q_full,
    output logic                      push,
    output brr_pkg::brr_item_t        push_item
);
    import brr_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    brr_item_t item_reg;
    logic      take;

    assign push     = valid_reg && !q_full;
    assign in_stall = !thr_ready || (valid_reg && q_full);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.word <= random_word;
            item_reg.is64 <= cfg.is64;
            item_reg.full <= cfg.is64 ? cfg.full64 : cfg.full32;
        end
    end

    assign push_item = item_reg;

endmodule

@@ design/brr_queue.sv @@
// ----------------------------------------------------------------------------
// brr_queue : short request queue
// Flop-based FIFO that lets the front end and the back end stall apart.
// ----------------------------------------------------------------------------
module brr_queue #(
    parameter int DEPTH = brr_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  brr_pkg::brr_item_t        push_item,
    input  logic                      pop,
    output brr_pkg::brr_item_t        pop_item,
    output logic                      full,
    output logic                      empty
);
    import brr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    brr_item_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg;
    logic [PTR_W-1:0]  wptr_next;
    logic [PTR_W-1:0]  rptr_reg;
    logic [PTR_W-1:0]  rptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");

endmodule

@@ design/brr_thresh.sv @@
// ----------------------------------------------------------------------------
// brr_thresh : rejection threshold divider
// Bit-serial restoring divider that computes (2^32 - w) mod w, one quotient
// bit per cycle, after reset and after every register write.
// ----------------------------------------------------------------------------
module brr_thresh (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      restart,
    input  brr_pkg::brr_cfg_t         cfg,
    output logic                      thr_ready,
    output logic [31:0]               thr
);
    import brr_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        TH_LOAD = 3'b001,
        TH_RUN  = 3'b010,
        TH_DONE = 3'b100
    } th_state_t;

    th_state_t         state_reg;
    th_state_t         state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [HALF_W-1:0] num_reg;
    logic [HALF_W-1:0] num_next;
    logic [HALF_W-1:0] rem_reg;
    logic [HALF_W-1:0] rem_next;
    logic [HALF_W:0]   rem_shift;

    assign rem_shift = {rem_reg, num_reg[HALF_W-1]};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            TH_LOAD:
            begin
                num_next   = 32'd0 - cfg.w32;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = TH_RUN;
            end
            TH_RUN:
            begin
                num_next = {num_reg[HALF_W-2:0], 1'b0};
                if (rem_shift >= {1'b0, cfg.w32})
                begin
                    rem_next = HALF_W'(rem_shift - {1'b0, cfg.w32});
                end
                else
                begin
                    rem_next = rem_shift[HALF_W-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = TH_DONE;
                end
            end
            TH_DONE:
            begin
                state_next = TH_DONE;
            end
            default:
            begin
                state_next = TH_LOAD;
            end
        endcase
        if (restart)
        begin
            state_next = TH_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TH_LOAD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign thr_ready = (state_reg == TH_DONE);
    assign thr       = rem_reg;

    a_rem_below_div : assert property (@(posedge clk) disable iff (!rst_n)
        (thr_ready && !cfg.full32) |-> (thr < cfg.w32))
        else $error("threshold not below range width");

endmodule

@@ design/brr_back.sv @@
// ----------------------------------------------------------------------------
// brr_back : reduction pipeline
// Stage one multiplies (32-bit modes), masks (64-bit modes) or passes a full-range
// word through; stage two applies the rejection test, adds the lower bound and holds the result.
// ----------------------------------------------------------------------------
module brr_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  brr_pkg::brr_item_t        pop_item,
    output logic                      pop,
    input  brr_pkg::brr_cfg_t         cfg,
    input  logic [31:0]               thr,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [63:0]               ranged_value,
    output logic                      accepted
);
    import brr_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [WORD_W-1:0] s1_data_reg;
    logic              s1_is64_reg;
    logic              s1_full_reg;
    logic [WORD_W-1:0] product;
    logic [WORD_W-1:0] s1_data_in;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] ranged_value_reg;
    logic              accepted_reg;
    logic [WORD_W-1:0] value_next;
    logic              ok_next;
    logic [HALF_W-1:0] frac;

    logic              out_ready;
    logic              s1_ready;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign pop       = !q_empty && s1_ready;

    assign product = {32'd0, pop_item.word[HALF_W-1:0]} * {32'd0, cfg.w32};

    always_comb
    begin
        if (pop_item.full)
        begin
            s1_data_in = pop_item.word;
        end
        else if (pop_item.is64)
        begin
            s1_data_in = pop_item.word & cfg.mask64;
        end
        else
        begin
            s1_data_in = product;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // low half of the product is the fraction tested against the threshold
    assign frac = s1_data_reg[HALF_W-1:0];

    always_comb
    begin
        value_next = '0;
        ok_next    = 1'b0;
        if (s1_full_reg)
        begin
            ok_next = 1'b1;
            if (s1_is64_reg)
            begin
                value_next = cfg.lo + s1_data_reg;
            end
            else
            begin
                value_next = {32'd0, cfg.lo[HALF_W-1:0] + s1_data_reg[HALF_W-1:0]};
            end
        end
        else if (s1_is64_reg)
        begin
            if (s1_data_reg < cfg.w64)
            begin
                ok_next    = 1'b1;
                value_next = cfg.lo + s1_data_reg;
            end
        end
        else if (!((frac < cfg.w32) && (frac < thr)))
        begin
            ok_next    = 1'b1;
            value_next = {32'd0, cfg.lo[HALF_W-1:0] + s1_data_reg[WORD_W-1:HALF_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_data_reg <= s1_data_in;
            s1_is64_reg <= pop_item.is64;
            s1_full_reg <= pop_item.full;
        end
        if (out_ready && s1_valid_reg)
        begin
            ranged_value_reg <= value_next;
            accepted_reg     <= ok_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ranged_value = ranged_value_reg;
    assign accepted     = accepted_reg;

    a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !accepted_reg) |-> (ranged_value_reg == '0))
        else $error("rejected word with nonzero value");

    a_stage_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("stage one dropped a request");

endmodule

@@ design/bounded_random_range_reducer.sv @@
// ----------------------------------------------------------------------------
// bounded_random_range_reducer : bounded random range reducer, top level
// Maps raw random words into [range_low, range_high] or rejects them.
// ----------------------------------------------------------------------------
// One result per random word, sustained at one request per clock while the
// output is not stalled, through the input register, the queue, the
// multiply/mask stage and the compare/add output stage; the single 32x32
// multiplier per cycle sets that rate. After reset and after every register
// write the input stalls while a bit-serial divider rebuilds the 32-bit
// rejection threshold (2^32 - w) mod w, one quotient bit per cycle. Registers
// sit at byte addresses 0 (range_low), 8 (range_high) and 16 (range_mode);
// write them only while no request is in flight.
module bounded_random_range_reducer #(
    parameter int QDEPTH = brr_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [brr_pkg::ADDR_W-1:0]    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [63:0]                   random_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [63:0]                   ranged_value,
    output logic                          accepted
);
    import brr_pkg::*;

    logic [WORD_W-1:0] range_low_reg;
    logic [WORD_W-1:0] range_high_reg;
    logic [1:0]        range_mode_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  reg_idx;

    brr_cfg_t          cfg;
    logic              thr_ready;
    logic [HALF_W-1:0] thr;
    logic              q_full;
    logic              q_empty;
    logic              push;
    logic              pop;
    brr_item_t         push_item;
    brr_item_t         pop_item;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= 64'd0;
            range_high_reg <= 64'h0000_0000_FFFF_FFFF;
            range_mode_reg <= 2'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_LOW:  range_low_reg  <= pwdata;
                REG_HIGH: range_high_reg <= pwdata;
                REG_MODE: range_mode_reg <= pwdata[1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LOW:  prdata = range_low_reg;
            REG_HIGH: prdata = range_high_reg;
            REG_MODE: prdata = {62'd0, range_mode_reg};
            default:  prdata = '0;
        endcase
    end

    assign cfg = derive_cfg(range_low_reg, range_high_reg, range_mode_reg);

    brr_thresh u_thresh (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (wr_en),
        .cfg       (cfg),
        .thr_ready (thr_ready),
        .thr       (thr)
    );

    brr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .random_word (random_word),
        .cfg         (cfg),
        .thr_ready   (thr_ready),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    brr_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    brr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .pop_item     (pop_item),
        .pop          (pop),
        .cfg          (cfg),
        .thr          (thr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ranged_value (ranged_value),
        .accepted     (accepted)
    );

endmodule

@@ test/bounded_random_range_reducer_tb.sv @@
// ----------------------------------------------------------------------------
// bounded_random_range_reducer_tb : self-checking bench for the range reducer
// Programs the range registers over APB, streams raw random words under
// random valid/stall bursts and compares every result against the directed
// table or a local predictor: Lemire threshold rejection for 32-bit ranges,
// mask rejection for 64-bit ranges, sign bias for the signed modes.
// ----------------------------------------------------------------------------
module bounded_random_range_reducer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import brr_pkg::*;

    localparam logic [1:0]  RANGE_U32 = 2'd0;
    localparam logic [1:0]  RANGE_U64 = 2'd1;
    localparam logic [1:0]  RANGE_S32 = 2'd2;
    localparam logic [1:0]  RANGE_S64 = 2'd3;
    localparam logic [31:0] BIAS32    = 32'h8000_0000;
    localparam logic [63:0] BIAS64    = 64'h8000_0000_0000_0000;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int CALM_ITEMS    = 200;
    localparam int HOLD_CYCLES   = 80;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        logic [63:0] value;
        logic        ok;
    } range_result_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] word;
        logic        known;
        logic [63:0] value;
        logic        ok;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] random_word;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] ranged_value;
    logic        accepted;

    // register shadow
    logic [63:0] cfg_low;
    logic [63:0] cfg_high;
    logic [1:0]  cfg_mode;

    range_result_t expected_results[$];
    int            mismatch_count;
    int            result_count;
    bit            idle_on;
    bit            hold_request;

    stim_row_t directed_table [DIRECTED_ROWS] = '{
        // reset range, full 32-bit width
        '{RANGE_U32, 64'h0, 64'hFFFF_FFFF, 64'h0, 1'b1, 64'h0, 1'b1},
        '{RANGE_U32, 64'h0, 64'hFFFF_FFFF, '1, 1'b1, 64'hFFFF_FFFF, 1'b1},
        '{RANGE_U32, 64'd10, 64'd10, 64'h0123_4567_89AB_CDEF, 1'b1, 64'd10, 1'b1},
        '{RANGE_U32, 64'd0, 64'd2, 64'd0, 1'b1, 64'd0, 1'b0},
        '{RANGE_U32, 64'd0, 64'd2, 64'd1, 1'b0, 64'd0, 1'b0},
        '{RANGE_U32, 64'd0, 64'hFFFF_FFFE, 64'd0, 1'b1, 64'd0, 1'b0},
        '{RANGE_U32, 64'd100, 64'd5, '1, 1'b0, 64'd0, 1'b0},
        '{RANGE_U32, 64'hFFFF_FFFF_0000_0003, 64'd9, 64'h5555_5555_AAAA_AAAA,
          1'b0, 64'd0, 1'b0},
        '{RANGE_U64, 64'd0, '1, 64'hDEAD_BEEF_0123_4567, 1'b1,
          64'hDEAD_BEEF_0123_4567, 1'b1},
        '{RANGE_U64, 64'd5, 64'd5, '1, 1'b1, 64'd5, 1'b1},
        '{RANGE_U64, 64'd0, 64'd4, 64'd7, 1'b1, 64'd0, 1'b0},
        '{RANGE_U64, 64'd0, 64'd4, 64'd4, 1'b1, 64'd4, 1'b1},
        // reversed by one: wraps to full width
        '{RANGE_U64, 64'd1, 64'd0, '1, 1'b1, 64'd0, 1'b1},
        '{RANGE_U64, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE, '1, 1'b1, 64'd0, 1'b0},
        '{RANGE_U64, 64'hFFFF_FFFF_FFFF_FF00, 64'h10, 64'hFF, 1'b0, 64'd0, 1'b0},
        '{RANGE_U64, 64'd0, BIAS64, '1, 1'b0, 64'd0, 1'b0},
        '{RANGE_S32, 64'h8000_0000, 64'h7FFF_FFFF, 64'd0, 1'b1, 64'h8000_0000, 1'b1},
        '{RANGE_S32, 64'hFFFF_FFFB, 64'd5, 64'h8000_0000, 1'b0, 64'd0, 1'b0},
        '{RANGE_S32, 64'd7, 64'hFFFF_FFF9, 64'h1234, 1'b0, 64'd0, 1'b0},
        '{RANGE_S32, 64'h7FFF_FFFF, 64'h7FFF_FFFF, '1, 1'b1, 64'h7FFF_FFFF, 1'b1},
        '{RANGE_S64, BIAS64, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 1'b1, BIAS64, 1'b1},
        '{RANGE_S64, 64'hFFFF_FFFF_FFFF_FFFD, 64'd3, 64'd6, 1'b0, 64'd0, 1'b0},
        '{RANGE_S64, 64'd10, 64'hFFFF_FFFF_FFFF_FFF6, 64'hA5A5_A5A5_A5A5_A5A5,
          1'b0, 64'd0, 1'b0},
        '{RANGE_S64, 64'h7FFF_FFFF_FFFF_FFFF, BIAS64, '1, 1'b0, 64'd0, 1'b0}
    };

    bounded_random_range_reducer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .random_word  (random_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ranged_value (ranged_value),
        .accepted     (accepted)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("bounded_random_range_reducer: mismatch");
        $finish;
    end

    // Maps one raw word into the shadowed range, or flags it rejected.
    function automatic range_result_t reduce_word(input logic [63:0] word);
        range_result_t r;
        logic [31:0]   lo32;
        logic [31:0]   hi32;
        logic [31:0]   span32;
        logic [31:0]   w32;
        logic [31:0]   thr;
        logic [31:0]   v32;
        logic [63:0]   prod;
        logic [63:0]   lo64;
        logic [63:0]   hi64;
        logic [63:0]   span64;
        logic [63:0]   w64;
        logic [63:0]   mask;
        logic [63:0]   v64;
        r = '0;
        if (!cfg_mode[0])
        begin
            lo32 = cfg_low[31:0];
            hi32 = cfg_high[31:0];
            if (cfg_mode == RANGE_S32)
            begin
                lo32 = lo32 - BIAS32;
                hi32 = hi32 - BIAS32;
            end
            span32 = hi32 - lo32;
            if (&span32)
            begin
                r.ok = 1'b1;
                v32  = lo32 + word[31:0];
            end
            else
            begin
                w32  = span32 + 32'd1;
                prod = {32'd0, word[31:0]} * {32'd0, w32};
                thr  = (32'd0 - w32) % w32;
                r.ok = !((prod[31:0] < w32) && (prod[31:0] < thr));
                v32  = lo32 + prod[63:32];
            end
            if (cfg_mode == RANGE_S32)
                v32 = v32 + BIAS32;
            r.value = r.ok ? {32'd0, v32} : 64'd0;
        end
        else
        begin
            lo64 = cfg_low;
            hi64 = cfg_high;
            if (cfg_mode == RANGE_S64)
            begin
                lo64 = lo64 - BIAS64;
                hi64 = hi64 - BIAS64;
            end
            span64 = hi64 - lo64;
            if (&span64)
            begin
                r.ok = 1'b1;
                v64  = lo64 + word;
            end
            else
            begin
                w64  = span64 + 64'd1;
                mask = span64;
                for (int s = 1; s < 64; s = s * 2)
                    mask = mask | (mask >> s);
                r.ok = (word & mask) < w64;
                v64  = lo64 + (word & mask);
            end
            if (cfg_mode == RANGE_S64)
                v64 = v64 + BIAS64;
            r.value = r.ok ? v64 : 64'd0;
        end
        return r;
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            2: return 64'($urandom_range(0, 15));
            3: return {$urandom, 32'd0};
            4: return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("ERROR result %0d: %s got %h want %h", result_count, what, got, want);
    endtask

    // Called at a falling edge; returns at a falling edge with psel still high.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_LOW:  cfg_low  = data;
            REG_HIGH: cfg_high = data;
            default:  cfg_mode = data[1:0];
        endcase
        @(negedge clk);
    endtask

    // Drains the pipe, then programs all three range registers.
    task automatic apply_range(input logic [1:0] mode, input logic [63:0] lo,
                               input logic [63:0] hi);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        write_reg(REG_LOW, lo);
        write_reg(REG_HIGH, hi);
        write_reg(REG_MODE, {62'd0, mode});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer(input logic [63:0] word, input logic known,
                         input range_result_t typed);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        random_word <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(known ? typed : reduce_word(word));
        @(negedge clk);
    endtask

    // receiver: random stall bursts plus one long hold-off
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        range_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", ranged_value, 64'd0);
            else
            begin
                want = expected_results.pop_front();
                if (ranged_value !== want.value)
                    report_mismatch("ranged_value", ranged_value, want.value);
                if (accepted !== want.ok)
                    report_mismatch("accepted", {63'd0, accepted}, {63'd0, want.ok});
            end
        end
    end

    initial
    begin
        stim_row_t   row;
        logic [1:0]  mode;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] span;
        int          shift;
        int          sent;
        int          phase;
        int          burst;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        random_word    = '0;
        rst_n          = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        idle_on        = 1'b1;
        hold_request   = 1'b0;
        cfg_low        = 64'd0;
        cfg_high       = 64'hFFFF_FFFF;
        cfg_mode       = RANGE_U32;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_table[i])
        begin
            row = directed_table[i];
            if (row.mode != cfg_mode || row.lo != cfg_low || row.hi != cfg_high)
                apply_range(row.mode, row.lo, row.hi);
            offer(row.word, row.known, '{value: row.value, ok: row.ok});
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0: lo = 64'd0;
                1: lo = '1;
                default: lo = {$urandom, $urandom};
            endcase
            shift = mode[0] ? $urandom_range(0, 63) : $urandom_range(0, 31);
            case ($urandom_range(0, 5))
                0: span = '1;
                1: span = 64'($urandom_range(0, 8));
                2: span = (64'd1 << shift) - 64'd1;
                3: span = {$urandom, $urandom};
                // just past a power of two: heaviest rejection
                4: span = 64'd1 << shift;
                default: span = ~64'($urandom_range(1, 100));
            endcase
            hi = mode[0] ? lo + span : {$urandom, lo[31:0] + span[31:0]};
            apply_range(mode, lo, hi);
            idle_on = (sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            if (phase == 1)
            begin
                // back-to-back requests against a held-off receiver
                idle_on      = 1'b0;
                hold_request = 1'b1;
            end
            burst = $urandom_range(30, 120);
            repeat (burst)
            begin
                offer(pick_word(), 1'b0, '0);
                sent++;
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("bounded_random_range_reducer: match");
        else
            $display("bounded_random_range_reducer: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
design/brr_pkg.sv
design/brr_front.sv
design/brr_queue.sv
design/brr_thresh.sv
design/brr_back.sv
design/bounded_random_range_reducer.sv
test/bounded_random_range_reducer_tb.sv
